// ===== hw/rtl/two_button_gesture_decoder_assert.svh =====
// Assertion macros shared by the gesture decoder modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef TWO_BUTTON_GESTURE_DECODER_ASSERT_SVH
`define TWO_BUTTON_GESTURE_DECODER_ASSERT_SVH

// Same-cycle implication
`define TBGD_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gesture decoder check failed");

// Next-cycle implication
`define TBGD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gesture decoder check failed");

`endif

// ===== hw/rtl/tbgd_pkg.sv =====
package tbgd_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int STATE_W = 4;
  localparam int EVENT_W = 4;
  localparam int INDEX_W = 2;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_REPEAT       = 2'd1;
  localparam logic [INDEX_W-1:0] REG_CHORD_ESCAPE = 2'd2;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LONG_PRESS_RST   = 16'd800;
  localparam logic [LIMIT_W-1:0] REPEAT_RST       = 16'd200;
  localparam logic [LIMIT_W-1:0] CHORD_ESCAPE_RST = 16'd2000;

  // Gesture states
  localparam logic [STATE_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [STATE_W-1:0] ST_LEFT       = 4'd1;
  localparam logic [STATE_W-1:0] ST_RIGHT      = 4'd2;
  localparam logic [STATE_W-1:0] ST_LEFT_LONG  = 4'd3;
  localparam logic [STATE_W-1:0] ST_RIGHT_LONG = 4'd4;
  localparam logic [STATE_W-1:0] ST_LR_DONE    = 4'd5;
  localparam logic [STATE_W-1:0] ST_RL_DONE    = 4'd6;
  localparam logic [STATE_W-1:0] ST_LR_LEFTUP  = 4'd7;
  localparam logic [STATE_W-1:0] ST_RL_RIGHTUP = 4'd8;
  localparam logic [STATE_W-1:0] ST_ESCAPED    = 4'd9;
  localparam logic [STATE_W-1:0] ST_CHORD_LR   = 4'd10;
  localparam logic [STATE_W-1:0] ST_CHORD_RL   = 4'd11;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE        = 4'd0;
  localparam logic [EVENT_W-1:0] EV_LEFT_TAP    = 4'd1;
  localparam logic [EVENT_W-1:0] EV_RIGHT_TAP   = 4'd2;
  localparam logic [EVENT_W-1:0] EV_LEFT_LONG   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_RIGHT_LONG  = 4'd4;
  localparam logic [EVENT_W-1:0] EV_LR_RUP      = 4'd5;
  localparam logic [EVENT_W-1:0] EV_RL_LUP      = 4'd6;
  localparam logic [EVENT_W-1:0] EV_LR_LUP_RUP  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_RL_RUP_LUP  = 4'd8;
  localparam logic [EVENT_W-1:0] EV_ESCAPE      = 4'd9;

  // Timing limits handed from the register file to the state machine
  typedef struct packed {
    logic [LIMIT_W-1:0] long_press_ms;
    logic [LIMIT_W-1:0] repeat_ms;
    logic [LIMIT_W-1:0] chord_escape_ms;
  } tbgd_cfg_t;

endpackage

// ===== hw/rtl/tbgd_poll_if.sv =====
interface tbgd_poll_if;
  import tbgd_pkg::*;

  logic              valid;
  logic              ready;
  logic              left_held;
  logic              right_held;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, left_held, right_held, now_ms, input ready);
  modport sink   (input valid, left_held, right_held, now_ms, output ready);
endinterface

// ===== hw/rtl/tbgd_event_if.sv =====
interface tbgd_event_if;
  import tbgd_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

// ===== hw/rtl/tbgd_cfg_if.sv =====
interface tbgd_cfg_if;
  import tbgd_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tbgd_cfg.sv =====
module tbgd_cfg (
  input  logic                  clk,
  input  logic                  rst,
  tbgd_cfg_if.sink              cfg,
  output tbgd_pkg::tbgd_cfg_t   limits
);
  import tbgd_pkg::*;

  tbgd_cfg_t regs;

  // Writes are always taken; an unknown index is dropped
  assign cfg.ready = 1'b1;
  assign limits    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.long_press_ms   <= LONG_PRESS_RST;
      regs.repeat_ms       <= REPEAT_RST;
      regs.chord_escape_ms <= CHORD_ESCAPE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LONG_PRESS:   regs.long_press_ms   <= cfg.data;
        REG_REPEAT:       regs.repeat_ms       <= cfg.data;
        REG_CHORD_ESCAPE: regs.chord_escape_ms <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/tbgd_fsm.sv =====
module tbgd_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          left_held,
  input  logic                          right_held,
  input  logic [tbgd_pkg::TIME_W-1:0]   now_ms,
  input  tbgd_pkg::tbgd_cfg_t           limits,
  output logic [tbgd_pkg::EVENT_W-1:0]  event_code
);
  import tbgd_pkg::*;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;
  logic [TIME_W-1:0]  hold_start_ms;
  logic [TIME_W-1:0]  hold_start_ms_next;
  logic [TIME_W-1:0]  elapsed;
  logic               over_long;
  logic               over_repeat;
  logic               over_escape;

  // Elapsed time against the stored hold start; negative never triggers
  assign elapsed     = now_ms - hold_start_ms;
  assign over_long   = !elapsed[TIME_W-1] &&
                       (elapsed[TIME_W-2:0] > {15'd0, limits.long_press_ms});
  assign over_repeat = !elapsed[TIME_W-1] &&
                       (elapsed[TIME_W-2:0] > {15'd0, limits.repeat_ms});
  assign over_escape = !elapsed[TIME_W-1] &&
                       (elapsed[TIME_W-2:0] > {15'd0, limits.chord_escape_ms});

  // One poll: states are checked in ascending order, so a state entered
  // earlier in the poll is handled again if its check lies below. Once the hold
  // start is moved to now, the fresh flag keeps every limit from triggering.
  always_comb begin
    logic [STATE_W-1:0] s;
    logic [EVENT_W-1:0] ev;
    logic               fresh;

    s     = (state > ST_CHORD_RL) ? ST_IDLE : state;
    ev    = EV_NONE;
    fresh = 1'b0;

    if (s == ST_IDLE) begin
      if (left_held)  begin s = ST_LEFT;  fresh = 1'b1; end
      if (right_held) begin s = ST_RIGHT; fresh = 1'b1; end
    end
    if (s == ST_LEFT) begin
      if (!fresh && over_long) begin
        s = ST_LEFT_LONG; ev = EV_LEFT_LONG; fresh = 1'b1;
      end
      if (!left_held) begin ev = EV_LEFT_TAP; s = ST_IDLE; end
      if (right_held) begin s = ST_CHORD_LR; fresh = 1'b1; end
    end
    if (s == ST_RIGHT) begin
      if (!fresh && over_long) begin
        s = ST_RIGHT_LONG; ev = EV_RIGHT_LONG; fresh = 1'b1;
      end
      if (!right_held) begin ev = EV_RIGHT_TAP; s = ST_IDLE; end
      if (left_held)   begin s = ST_CHORD_RL; fresh = 1'b1; end
    end
    if (s == ST_LEFT_LONG) begin
      if (!fresh && over_repeat) begin ev = EV_LEFT_LONG; fresh = 1'b1; end
      if (!left_held) s = ST_IDLE;
    end
    if (s == ST_RIGHT_LONG) begin
      if (!fresh && over_repeat) begin ev = EV_RIGHT_LONG; fresh = 1'b1; end
      if (!right_held) s = ST_IDLE;
    end
    if (s == ST_LR_DONE) begin
      if (!left_held) s = ST_IDLE;
      if (right_held) begin s = ST_CHORD_LR; fresh = 1'b1; end
    end
    if (s == ST_RL_DONE) begin
      if (!right_held) s = ST_IDLE;
      if (left_held)   begin s = ST_CHORD_RL; fresh = 1'b1; end
    end
    if (s == ST_LR_LEFTUP) begin
      if (!right_held) begin s = ST_IDLE; ev = EV_LR_LUP_RUP; end
      if (left_held)   begin s = ST_CHORD_LR; fresh = 1'b1; end
    end
    if (s == ST_RL_RIGHTUP) begin
      if (!left_held) begin s = ST_IDLE; ev = EV_RL_RUP_LUP; end
      if (right_held) begin s = ST_CHORD_RL; fresh = 1'b1; end
    end
    if (s == ST_ESCAPED) begin
      if (!left_held && !right_held) s = ST_IDLE;
    end
    if (s == ST_CHORD_LR) begin
      if (!fresh && over_escape) begin s = ST_ESCAPED; ev = EV_ESCAPE; end
      if (!left_held)  s = ST_LR_LEFTUP;
      if (!right_held) begin ev = EV_LR_RUP; s = ST_LR_DONE; end
    end
    if (s == ST_CHORD_RL) begin
      if (!fresh && over_escape) begin s = ST_ESCAPED; ev = EV_ESCAPE; end
      if (!left_held)  begin ev = EV_RL_LUP; s = ST_RL_DONE; end
      if (!right_held) s = ST_RL_RIGHTUP;
    end

    state_next         = s;
    event_code         = ev;
    hold_start_ms_next = fresh ? now_ms : hold_start_ms;
  end

  // State advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hold_start_ms <= '0;
    end else if (step) begin
      state         <= state_next;
      hold_start_ms <= hold_start_ms_next;
    end
  end

`include "two_button_gesture_decoder_assert.svh"

  `TBGD_ASSERT_HOLDS(a_state_legal, 1'b1, state <= ST_CHORD_RL)
  `TBGD_ASSERT_NEXT(a_state_idle_hold, !step, $stable(state) && $stable(hold_start_ms))
  `TBGD_ASSERT_NEXT(a_hold_moves_to_now, step && (hold_start_ms_next != hold_start_ms),
                    hold_start_ms == $past(now_ms))

endmodule

// ===== hw/rtl/two_button_gesture_decoder.sv =====
// Two-button gesture decoder.
// poll (sink): one item per button poll with left_held, right_held and the
//   millisecond timestamp now_ms. result (source): one item per poll with
//   event_code (0 none, 1/2 taps, 3/4 long press or repeat, 5-8 chords,
//   9 escape). cfg (sink): register writes, index 0 long_press_ms,
//   1 repeat_ms, 2 chord_escape_ms; always ready, unknown index ignored.
// An accepted poll is held in the input register while the gesture state
// machine decodes it combinationally; its result is loaded into the result
// register when that register is empty or being taken, and is offered from
// there. Throughput is one poll per cycle while result is not stalled, set
// by the single state update per poll through the state machine.
// When result is stalled the result register holds its item, the input
// register holds the next poll, and poll.ready drops until result moves.
// Reset clears both registers, sets the state to idle with a zero hold
// start, and loads the limits 800, 200 and 2000 ms.
module two_button_gesture_decoder (
  input  logic        clk,
  input  logic        rst,
  tbgd_poll_if.sink   poll,
  tbgd_event_if.source result,
  tbgd_cfg_if.sink    cfg
);
  import tbgd_pkg::*;

  tbgd_cfg_t          limits;
  logic               in_valid;
  logic               in_left;
  logic               in_right;
  logic [TIME_W-1:0]  in_now;
  logic               step;
  logic [EVENT_W-1:0] event_next;
  logic               out_valid;
  logic [EVENT_W-1:0] out_code;

  tbgd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  tbgd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .left_held  (in_left),
    .right_held (in_right),
    .now_ms     (in_now),
    .limits     (limits),
    .event_code (event_next)
  );

  // Item moves from input register to result register
  assign step       = in_valid && (!out_valid || result.ready);
  assign poll.ready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_left  <= poll.left_held;
      in_right <= poll.right_held;
      in_now   <= poll.now_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_code <= event_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.event_code = out_code;

`include "two_button_gesture_decoder_assert.svh"

  `TBGD_ASSERT_NEXT(a_step_fills_result, step, out_valid && (out_code == $past(event_next)))
  `TBGD_ASSERT_NEXT(a_stall_keeps_input, in_valid && !step, in_valid)
  `TBGD_ASSERT_HOLDS(a_result_code_range, out_valid, out_code <= EV_ESCAPE)

endmodule

// ===== test/two_button_gesture_decoder_test.sv =====
`timescale 1ns / 100ps

module two_button_gesture_decoder_test;
  import tbgd_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 7;
  localparam int MAX_IDLE    = 17;
  localparam int PHASE_POLLS = 165;
  localparam int RUN_LIMIT   = 400000;
  localparam int DRAIN_TICKS = 4;

  // Index past the last register; writes to it must be dropped
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;

  // Gesture predictor and expected-event store
  class gesture_scoreboard;
    logic [LIMIT_W-1:0] long_press_ms;
    logic [LIMIT_W-1:0] repeat_ms;
    logic [LIMIT_W-1:0] chord_escape_ms;
    logic [STATE_W-1:0] state;
    logic [TIME_W-1:0]  hold_start;
    logic [EVENT_W-1:0] pending_events[$];
    int polls;
    int events;
    int errors;
    int seen[16];

    function new();
      long_press_ms   = LONG_PRESS_RST;
      repeat_ms       = REPEAT_RST;
      chord_escape_ms = CHORD_ESCAPE_RST;
      state           = ST_IDLE;
      hold_start      = '0;
      polls           = 0;
      events          = 0;
      errors          = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_limit(logic [INDEX_W-1:0] idx, logic [LIMIT_W-1:0] value);
      case (idx)
        REG_LONG_PRESS:   long_press_ms = value;
        REG_REPEAT:       repeat_ms = value;
        REG_CHORD_ESCAPE: chord_escape_ms = value;
        default: ;
      endcase
    endfunction

    // Wrapped difference, negative spans never expire, strict compare
    function bit held_past(logic [TIME_W-1:0] now, logic [LIMIT_W-1:0] limit);
      logic [TIME_W-1:0] span;
      span = now - hold_start;
      return !span[TIME_W-1] && (span > {{(TIME_W-LIMIT_W){1'b0}}, limit});
    endfunction

    // States are visited in ascending order; later checks see earlier moves
    function void note_poll(bit lk, bit rk, logic [TIME_W-1:0] now);
      logic [STATE_W-1:0] s;
      logic [EVENT_W-1:0] ev;
      s  = state;
      ev = EV_NONE;
      if (s > ST_CHORD_RL) s = ST_IDLE;
      if (s == ST_IDLE) begin
        if (lk) begin s = ST_LEFT; hold_start = now; end
        if (rk) begin s = ST_RIGHT; hold_start = now; end
      end
      if (s == ST_LEFT) begin
        if (held_past(now, long_press_ms)) begin
          s = ST_LEFT_LONG; ev = EV_LEFT_LONG; hold_start = now;
        end
        if (!lk) begin ev = EV_LEFT_TAP; s = ST_IDLE; end
        if (rk) begin s = ST_CHORD_LR; hold_start = now; end
      end
      if (s == ST_RIGHT) begin
        if (held_past(now, long_press_ms)) begin
          s = ST_RIGHT_LONG; ev = EV_RIGHT_LONG; hold_start = now;
        end
        if (!rk) begin ev = EV_RIGHT_TAP; s = ST_IDLE; end
        if (lk) begin s = ST_CHORD_RL; hold_start = now; end
      end
      if (s == ST_LEFT_LONG) begin
        if (held_past(now, repeat_ms)) begin ev = EV_LEFT_LONG; hold_start = now; end
        if (!lk) s = ST_IDLE;
      end
      if (s == ST_RIGHT_LONG) begin
        if (held_past(now, repeat_ms)) begin ev = EV_RIGHT_LONG; hold_start = now; end
        if (!rk) s = ST_IDLE;
      end
      if (s == ST_LR_DONE) begin
        if (!lk) s = ST_IDLE;
        if (rk) begin s = ST_CHORD_LR; hold_start = now; end
      end
      if (s == ST_RL_DONE) begin
        if (!rk) s = ST_IDLE;
        if (lk) begin s = ST_CHORD_RL; hold_start = now; end
      end
      if (s == ST_LR_LEFTUP) begin
        if (!rk) begin s = ST_IDLE; ev = EV_LR_LUP_RUP; end
        if (lk) begin s = ST_CHORD_LR; hold_start = now; end
      end
      if (s == ST_RL_RIGHTUP) begin
        if (!lk) begin s = ST_IDLE; ev = EV_RL_RUP_LUP; end
        if (rk) begin s = ST_CHORD_RL; hold_start = now; end
      end
      if (s == ST_ESCAPED) begin
        if (!lk && !rk) s = ST_IDLE;
      end
      if (s == ST_CHORD_LR) begin
        if (held_past(now, chord_escape_ms)) begin s = ST_ESCAPED; ev = EV_ESCAPE; end
        if (!lk) s = ST_LR_LEFTUP;
        if (!rk) begin ev = EV_LR_RUP; s = ST_LR_DONE; end
      end
      if (s == ST_CHORD_RL) begin
        if (held_past(now, chord_escape_ms)) begin s = ST_ESCAPED; ev = EV_ESCAPE; end
        if (!lk) begin ev = EV_RL_LUP; s = ST_RL_DONE; end
        if (!rk) s = ST_RL_RIGHTUP;
      end
      state = s;
      pending_events.push_back(ev);
      polls++;
    endfunction

    function void check_event(logic [EVENT_W-1:0] got);
      logic [EVENT_W-1:0] want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event item: expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      events++;
      if (got !== want) begin
        $display("%0t: event_code mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end else begin
        seen[want]++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   setting_count = 0;
  bit   poll_calm = 1'b0;
  bit   sink_calm = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  gesture_scoreboard sb = new();

  tbgd_poll_if  poll_ch();
  tbgd_event_if event_ch();
  tbgd_cfg_if   cfg_ch();

  two_button_gesture_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (event_ch),
    .cfg    (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout with %0d events still due", $time, sb.pending_events.size());
      $display("** two_button_gesture_decoder: FAILED **");
      $finish;
    end
  end

  // Wait per item; calm stretches run with no idling at all
  function automatic int idle_draw(ref bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Next timestamp: often near the limit in play, else within half of it; sometimes far off, behind or random
  function automatic logic [TIME_W-1:0] advance_ms(logic [TIME_W-1:0] t,
                                                   logic [LIMIT_W-1:0] lim);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7:  return t + $urandom_range(0, lim / 2 + 1);
      8, 9, 10, 11, 12, 13, 14, 15, 16:
        return t + lim + $urandom_range(0, 3) - 1;
      17:      return t + $urandom_range(0, 200000);
      18:      return t - $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stalls, check each accepted item
  initial begin : event_sink
    int stall;
    event_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_draw(sink_calm);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      event_ch.ready <= 1'b1;
      do @(posedge clk); while (event_ch.valid !== 1'b1);
      sb.check_event(event_ch.event_code);
    end
  end

  task automatic send_poll(bit l, bit r, logic [TIME_W-1:0] now);
    int gap;
    gap = idle_draw(poll_calm);
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid      <= 1'b1;
    poll_ch.left_held  <= l;
    poll_ch.right_held <= r;
    poll_ch.now_ms     <= now;
    do @(posedge clk); while (poll_ch.ready !== 1'b1);
    sb.note_poll(l, r, now);
  endtask

  task automatic hold_keys(bit l, bit r, logic [LIMIT_W-1:0] lim, int n);
    repeat (n) begin
      clock_ms = advance_ms(clock_ms, lim);
      send_poll(l, r, clock_ms);
    end
  endtask

  // Drain all due events, then let the pipeline settle
  task automatic wait_idle();
    poll_ch.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  // Back-to-back register writes; valid stays high across the burst
  task automatic program_limits(logic [LIMIT_W-1:0] lp, logic [LIMIT_W-1:0] rp,
                                logic [LIMIT_W-1:0] ce, bit poke_spare);
    logic [INDEX_W-1:0] idx[4];
    logic [LIMIT_W-1:0] val[4];
    int n;
    idx[0] = REG_LONG_PRESS;   val[0] = lp;
    idx[1] = REG_REPEAT;       val[1] = rp;
    idx[2] = REG_CHORD_ESCAPE; val[2] = ce;
    idx[3] = REG_SPARE;        val[3] = LIMIT_W'($urandom);
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      sb.set_limit(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
    setting_count++;
  endtask

  // Hand-picked gestures at the reset limits (800 / 200 / 2000 ms)
  task automatic directed_polls();
    send_poll(0, 0, 32'd0);
    // taps
    send_poll(1, 0, 32'd100);
    send_poll(0, 0, 32'd150);
    send_poll(0, 1, 32'd200);
    send_poll(0, 0, 32'd300);
    // left long press: exactly at limit does not fire, one past does, then repeat
    send_poll(1, 0, 32'd1000);
    send_poll(1, 0, 32'd1800);
    send_poll(1, 0, 32'd1801);
    send_poll(1, 0, 32'd2002);
    send_poll(0, 0, 32'd2010);
    // right long press
    send_poll(0, 1, 32'd3000);
    send_poll(0, 1, 32'd3801);
    send_poll(0, 0, 32'd3802);
    // left-then-right chord: right up first, re-chord, left up first
    send_poll(1, 0, 32'd5000);
    send_poll(1, 1, 32'd5010);
    send_poll(1, 0, 32'd5020);
    send_poll(1, 1, 32'd5030);
    send_poll(0, 1, 32'd5040);
    send_poll(0, 0, 32'd5050);
    // right-then-left chord: left up first, re-chord, right up first
    send_poll(0, 1, 32'd6000);
    send_poll(1, 1, 32'd6010);
    send_poll(0, 1, 32'd6020);
    send_poll(1, 1, 32'd6030);
    send_poll(1, 0, 32'd6040);
    send_poll(0, 0, 32'd6050);
    // both keys from idle, held to escape
    send_poll(1, 1, 32'd9000);
    send_poll(1, 1, 32'd11000);
    send_poll(1, 1, 32'd11001);
    send_poll(0, 0, 32'd11002);
    // timestamp behind the hold start never expires; wrap at all-ones
    send_poll(1, 0, 32'h8000_0000);
    send_poll(1, 0, 32'h0000_0001);
    send_poll(0, 0, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;
  endtask

  // Mostly well-formed gestures with random timing, some random noise
  task automatic random_polls(int count);
    int target;
    bit first_r;
    bit drop_first;
    target = sb.polls + count;
    while (sb.polls < target) begin
      first_r    = 1'($urandom_range(0, 1));
      drop_first = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0, 1: begin
          // single key: tap or long press with repeats
          hold_keys(!first_r, first_r, sb.long_press_ms, 1);
          hold_keys(!first_r, first_r, sb.repeat_ms, $urandom_range(0, 4));
          hold_keys(0, 0, sb.long_press_ms, 1);
        end
        2, 3: begin
          // chord, either release order
          hold_keys(!first_r, first_r, sb.long_press_ms, $urandom_range(1, 2));
          hold_keys(1, 1, sb.chord_escape_ms, $urandom_range(1, 2));
          if (drop_first) hold_keys(first_r, !first_r, sb.chord_escape_ms, $urandom_range(1, 2));
          else hold_keys(!first_r, first_r, sb.chord_escape_ms, $urandom_range(1, 2));
          hold_keys(0, 0, sb.long_press_ms, 1);
        end
        4: begin
          // long chord toward escape
          hold_keys(1, 1, sb.chord_escape_ms, $urandom_range(2, 4));
          hold_keys(first_r, !first_r, sb.chord_escape_ms, $urandom_range(0, 2));
          hold_keys(0, 0, sb.long_press_ms, 1);
        end
        default: begin
          repeat ($urandom_range(1, 5))
            hold_keys(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? sb.long_press_ms : sb.chord_escape_ms, 1);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    rst                <= 1'b1;
    poll_ch.valid      <= 1'b0;
    poll_ch.left_held  <= 1'b0;
    poll_ch.right_held <= 1'b0;
    poll_ch.now_ms     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_LONG_PRESS;
    cfg_ch.data        <= '0;
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;

    directed_polls();
    random_polls(PHASE_POLLS);

    // zero limits, plus a write to the unused index
    wait_idle();
    program_limits('0, '0, '0, 1'b1);
    random_polls(PHASE_POLLS);

    // largest limits
    wait_idle();
    program_limits('1, '1, '1, 1'b0);
    random_polls(PHASE_POLLS);

    // short limits
    wait_idle();
    program_limits(LIMIT_W'($urandom_range(1, 20)), LIMIT_W'($urandom_range(1, 10)),
                   LIMIT_W'($urandom_range(1, 40)), 1'b1);
    random_polls(PHASE_POLLS);

    // fully random limits
    wait_idle();
    program_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom), 1'b0);
    random_polls(PHASE_POLLS);

    // mixed extremes
    wait_idle();
    program_limits('1, '0, LIMIT_W'($urandom_range(0, 3000)), 1'b0);
    random_polls(PHASE_POLLS);

    wait_idle();
    $display("Run: %0d polls, %0d events checked, %0d limit settings incl. zero and max",
             sb.polls, sb.events, setting_count + 1);
    $display("Events by code 0-9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4],
             sb.seen[5], sb.seen[6], sb.seen[7], sb.seen[8], sb.seen[9]);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("** two_button_gesture_decoder: PASSED **");
    end else begin
      $display("** two_button_gesture_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tbgd_pkg.sv
hw/rtl/tbgd_poll_if.sv
hw/rtl/tbgd_event_if.sv
hw/rtl/tbgd_cfg_if.sv
hw/rtl/tbgd_cfg.sv
hw/rtl/tbgd_fsm.sv
hw/rtl/two_button_gesture_decoder.sv
test/two_button_gesture_decoder_test.sv
